// ----- src/segi_pkg.sv -----
package segi_pkg;

  // coordinate width of every input and output point
  localparam int COORD_BITS = 24;
  // segment difference, one bit wider than a coordinate
  localparam int DIFF_BITS  = COORD_BITS + 1;
  // product of two differences
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  // cross product (difference of two products)
  localparam int CROSS_BITS = PROD_BITS + 1;
  // low slice of |tnum| fed to the first partial product
  localparam int SPLIT_BITS = (CROSS_BITS + 1) / 2;
  localparam int HIGH_BITS  = CROSS_BITS - SPLIT_BITS;
  // magnitude of |a| * |tnum|, the dividend
  localparam int MAG_BITS   = COORD_BITS + CROSS_BITS;

  // control word traveling beside the divider
  typedef struct packed {
    logic                         valid;
    logic                         hit;
    logic                         neg_x;
    logic                         neg_y;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
  } side_t;

endpackage

// ----- src/segi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// The quotient is known to stay below 2**COORD_BITS, so COORD_BITS stages suffice.
// A new word is taken every cycle.
module segi_div (
  input  logic                               clk,
  input  logic [segi_pkg::MAG_BITS-1:0]      num,
  input  logic [segi_pkg::CROSS_BITS-1:0]    den,
  output logic [segi_pkg::COORD_BITS-1:0]    quot
);

  logic [segi_pkg::MAG_BITS-1:0]   rem   [0:segi_pkg::COORD_BITS];
  logic [segi_pkg::CROSS_BITS-1:0] den_r [0:segi_pkg::COORD_BITS];
  logic [segi_pkg::COORD_BITS-1:0] q     [0:segi_pkg::COORD_BITS];

  assign rem[0]   = num;
  assign den_r[0] = den;
  assign q[0]     = '0;

  for (genvar k = 0; k < segi_pkg::COORD_BITS; k++) begin : g_stage
    localparam int SH = segi_pkg::COORD_BITS - 1 - k;
    logic [segi_pkg::MAG_BITS-1:0] dsh;
    logic                          ge;

    // trial subtract of the shifted divisor
    assign dsh = segi_pkg::MAG_BITS'(den_r[k]) << SH;
    assign ge  = rem[k] >= dsh;

    always_ff @(posedge clk) begin
      rem[k+1]   <= ge ? rem[k] - dsh : rem[k];
      q[k+1]     <= ge ? (q[k] | (segi_pkg::COORD_BITS'(1) << SH)) : q[k];
      den_r[k+1] <= den_r[k];
    end
  end

  assign quot = q[segi_pkg::COORD_BITS];

endmodule

// ----- src/segment_intersection.sv -----
// Segment intersection: a word is taken whenever start is high; busy is always low, so a
// new pair of segments can enter every cycle. Each word gives one result, shown for one
// cycle with done high, once it has passed six arithmetic stages, the divider's one stage
// per quotient bit, and the output register. The receiver cannot stall; results must be
// taken as they appear. Parallel, collinear or degenerate segments report no hit; a miss
// gives a zero point.
module segment_intersection (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [segi_pkg::COORD_BITS-1:0]  a_start_x,
  input  logic signed [segi_pkg::COORD_BITS-1:0]  a_start_y,
  input  logic signed [segi_pkg::COORD_BITS-1:0]  a_end_x,
  input  logic signed [segi_pkg::COORD_BITS-1:0]  a_end_y,
  input  logic signed [segi_pkg::COORD_BITS-1:0]  b_start_x,
  input  logic signed [segi_pkg::COORD_BITS-1:0]  b_start_y,
  input  logic signed [segi_pkg::COORD_BITS-1:0]  b_end_x,
  input  logic signed [segi_pkg::COORD_BITS-1:0]  b_end_y,
  output logic                                    done,
  output logic                                    hit,
  output logic signed [segi_pkg::COORD_BITS-1:0]  point_x,
  output logic signed [segi_pkg::COORD_BITS-1:0]  point_y
);

  localparam int CW = segi_pkg::COORD_BITS;
  localparam int DW = segi_pkg::DIFF_BITS;
  localparam int PW = segi_pkg::PROD_BITS;
  localparam int XW = segi_pkg::CROSS_BITS;
  localparam int SW = segi_pkg::SPLIT_BITS;
  localparam int HW = segi_pkg::HIGH_BITS;
  localparam int MW = segi_pkg::MAG_BITS;

  assign busy = 1'b0;

  // stage 1: segment and offset differences
  logic                 v1;
  logic signed [DW-1:0] s1_ax, s1_ay, s1_bx, s1_by, s1_dx, s1_dy;
  logic signed [CW-1:0] s1_sx, s1_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    s1_ax <= DW'(a_end_x) - DW'(a_start_x);
    s1_ay <= DW'(a_end_y) - DW'(a_start_y);
    s1_bx <= DW'(b_end_x) - DW'(b_start_x);
    s1_by <= DW'(b_end_y) - DW'(b_start_y);
    s1_dx <= DW'(a_start_x) - DW'(b_start_x);
    s1_dy <= DW'(a_start_y) - DW'(b_start_y);
    s1_sx <= a_start_x;
    s1_sy <= a_start_y;
  end

  // stage 2: six cross-product terms
  logic                 v2;
  logic signed [PW-1:0] m_ab0, m_ab1, m_ad0, m_ad1, m_bd0, m_bd1;
  logic signed [DW-1:0] s2_ax, s2_ay;
  logic signed [CW-1:0] s2_sx, s2_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    m_ab0 <= PW'(s1_ax) * PW'(s1_by);
    m_ab1 <= PW'(s1_ay) * PW'(s1_bx);
    m_ad0 <= PW'(s1_ax) * PW'(s1_dy);
    m_ad1 <= PW'(s1_ay) * PW'(s1_dx);
    m_bd0 <= PW'(s1_bx) * PW'(s1_dy);
    m_bd1 <= PW'(s1_by) * PW'(s1_dx);
    s2_ax <= s1_ax;
    s2_ay <= s1_ay;
    s2_sx <= s1_sx;
    s2_sy <= s1_sy;
  end

  // stage 3: denominator and both numerators
  logic                 v3;
  logic signed [XW-1:0] den3, snum3, tnum3;
  logic signed [DW-1:0] s3_ax, s3_ay;
  logic signed [CW-1:0] s3_sx, s3_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    den3  <= XW'(m_ab0) - XW'(m_ab1);
    snum3 <= XW'(m_ad0) - XW'(m_ad1);
    tnum3 <= XW'(m_bd0) - XW'(m_bd1);
    s3_ax <= s2_ax;
    s3_ay <= s2_ay;
    s3_sx <= s2_sx;
    s3_sy <= s2_sy;
  end

  // stage 4: range tests, magnitudes and quotient signs
  logic          s_ok, t_ok, hit_next;
  logic          v4, s4_hit, s4_negx, s4_negy;
  logic [XW-1:0] s4_tmag, s4_dmag;
  logic [CW-1:0] s4_axm, s4_aym;
  logic signed [CW-1:0] s4_sx, s4_sy;
  logic          den_neg, t_neg;

  assign den_neg = den3[XW-1];
  assign t_neg   = tnum3[XW-1];
  assign s_ok = den_neg ? (snum3 <= 0 && den3 <= snum3) : (snum3 >= 0 && snum3 <= den3);
  assign t_ok = den_neg ? (tnum3 <= 0 && den3 <= tnum3) : (tnum3 >= 0 && tnum3 <= den3);
  assign hit_next = (den3 != 0) && s_ok && t_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    s4_hit  <= hit_next;
    s4_tmag <= t_neg ? XW'(-tnum3) : XW'(tnum3);
    s4_dmag <= den_neg ? XW'(-den3) : XW'(den3);
    s4_axm  <= s3_ax[DW-1] ? CW'(-s3_ax) : CW'(s3_ax);
    s4_aym  <= s3_ay[DW-1] ? CW'(-s3_ay) : CW'(s3_ay);
    s4_negx <= s3_ax[DW-1] ^ t_neg ^ den_neg;
    s4_negy <= s3_ay[DW-1] ^ t_neg ^ den_neg;
    s4_sx   <= s3_sx;
    s4_sy   <= s3_sy;
  end

  // stage 5: partial products of |a| * |tnum|
  logic             v5, s5_hit, s5_negx, s5_negy;
  logic [CW+SW-1:0] px_lo, py_lo;
  logic [CW+HW-1:0] px_hi, py_hi;
  logic [XW-1:0]    s5_dmag;
  logic signed [CW-1:0] s5_sx, s5_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    px_lo   <= (CW+SW)'(s4_axm) * (CW+SW)'(s4_tmag[SW-1:0]);
    px_hi   <= (CW+HW)'(s4_axm) * (CW+HW)'(s4_tmag[XW-1:SW]);
    py_lo   <= (CW+SW)'(s4_aym) * (CW+SW)'(s4_tmag[SW-1:0]);
    py_hi   <= (CW+HW)'(s4_aym) * (CW+HW)'(s4_tmag[XW-1:SW]);
    s5_dmag <= s4_dmag;
    s5_hit  <= s4_hit;
    s5_negx <= s4_negx;
    s5_negy <= s4_negy;
    s5_sx   <= s4_sx;
    s5_sy   <= s4_sy;
  end

  // stage 6: combine partial products into the dividend
  logic [MW-1:0]      s6_px, s6_py;
  logic [XW-1:0]      s6_dmag;
  segi_pkg::side_t    side [0:CW];

  always_ff @(posedge clk) begin
    if (rst) begin
      side[0].valid <= 1'b0;
    end else begin
      side[0].valid <= v5;
    end
    s6_px           <= MW'(px_lo) + (MW'(px_hi) << SW);
    s6_py           <= MW'(py_lo) + (MW'(py_hi) << SW);
    s6_dmag         <= s5_dmag;
    side[0].hit     <= s5_hit;
    side[0].neg_x   <= s5_negx;
    side[0].neg_y   <= s5_negy;
    side[0].start_x <= s5_sx;
    side[0].start_y <= s5_sy;
  end

  // dividers, with the control word delayed alongside
  logic [CW-1:0] qx, qy;

  segi_div u_div_x (.clk(clk), .num(s6_px), .den(s6_dmag), .quot(qx));
  segi_div u_div_y (.clk(clk), .num(s6_py), .den(s6_dmag), .quot(qy));

  for (genvar k = 0; k < CW; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side[k+1].valid <= 1'b0;
      end else begin
        side[k+1].valid <= side[k].valid;
      end
      side[k+1].hit     <= side[k].hit;
      side[k+1].neg_x   <= side[k].neg_x;
      side[k+1].neg_y   <= side[k].neg_y;
      side[k+1].start_x <= side[k].start_x;
      side[k+1].start_y <= side[k].start_y;
    end
  end

  // output register: sign the quotient and offset from the start of A
  logic [CW-1:0] ox, oy;

  assign ox = side[CW].start_x + (side[CW].neg_x ? -qx : qx);
  assign oy = side[CW].start_y + (side[CW].neg_y ? -qy : qy);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side[CW].valid;
    end
    hit     <= side[CW].hit;
    point_x <= side[CW].hit ? ox : '0;
    point_y <= side[CW].hit ? oy : '0;
  end

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = segi_pkg::COORD_BITS;
  localparam int LATENCY = CB + 7;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    coord_t asx, asy, aex, aey, bsx, bsy, bex, bey;
  } seg_pair_t;

  typedef struct {
    logic   hit;
    coord_t px, py;
  } crossing_t;

  logic clk, rst, start, busy, done, hit;
  coord_t a_start_x, a_start_y, a_end_x, a_end_y;
  coord_t b_start_x, b_start_y, b_end_x, b_end_y;
  coord_t point_x, point_y;

  segment_intersection dut (.*);

  seg_pair_t pending_pairs[$];
  crossing_t expected_crossings[$];
  int  fail_count = 0;
  int  stall_left = 0;
  bit  calm_tail = 0;
  int  idle_cycles = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // exact crossing computation, 128-bit signed intermediates
  function automatic crossing_t predict_crossing(seg_pair_t p);
    crossing_t r;
    logic signed [127:0] ax, ay, bx, by, dx, dy, den, snum, tnum, qx, qy;
    logic signed [127:0] prx, pry;
    logic s_ok, t_ok;
    ax = p.aex - p.asx;  ay = p.aey - p.asy;
    bx = p.bex - p.bsx;  by = p.bey - p.bsy;
    dx = p.asx - p.bsx;  dy = p.asy - p.bsy;
    den  = ax * by - ay * bx;
    snum = ax * dy - ay * dx;
    tnum = bx * dy - by * dx;
    r.hit = 0; r.px = '0; r.py = '0;
    if (den == 0) return r;
    if (den < 0) begin
      s_ok = (snum <= 0) && (den <= snum);
      t_ok = (tnum <= 0) && (den <= tnum);
    end else begin
      s_ok = (snum >= 0) && (snum <= den);
      t_ok = (tnum >= 0) && (tnum <= den);
    end
    if (!(s_ok && t_ok)) return r;
    // SV signed division truncates toward zero
    prx = ax * tnum;
    pry = ay * tnum;
    qx = prx / den;
    qy = pry / den;
    r.hit = 1;
    r.px = coord_t'(p.asx + qx);
    r.py = coord_t'(p.asy + qy);
    return r;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 64)) - 32);
      default: return coord_t'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  task automatic push_pair(coord_t asx, asy, aex, aey, bsx, bsy, bex, bey);
    seg_pair_t p;
    p.asx = asx; p.asy = asy; p.aex = aex; p.aey = aey;
    p.bsx = bsx; p.bsy = bsy; p.bex = bex; p.bey = bey;
    pending_pairs.push_back(p);
  endtask

  // build a pair that crosses at a chosen point half of the time
  task automatic push_random_pair();
    coord_t cx, cy, dxa, dya, dxb, dyb, lim;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      push_pair(rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0));
    end else if (mode < 4) begin
      push_pair(rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1),
                rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1));
    end else begin
      lim = (mode < 7) ? coord_t'(4000) : coord_t'(2000000);
      cx = rand_coord(0) / 4;  cy = rand_coord(0) / 4;
      dxa = coord_t'($signed($urandom_range(0, 2*lim)) - lim);
      dya = coord_t'($signed($urandom_range(0, 2*lim)) - lim);
      dxb = coord_t'($signed($urandom_range(0, 2*lim)) - lim);
      dyb = coord_t'($signed($urandom_range(0, 2*lim)) - lim);
      if (mode == 9) begin
        // parallel: B reuses A's direction
        dxb = dxa; dyb = dya;
      end
      push_pair(cx - dxa, cy - dya, cx + dxa, cy + dya,
                cx - dxb, cy - dyb, cx + dxb, cy + dyb);
    end
  endtask

  // stimulus
  initial begin
    coord_t mx, mn;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};
    // plain crossing, an X through the origin
    push_pair(-10, -10, 10, 10, -10, 10, 10, -10);
    // endpoint touch: both starts, A's end on B's start, B's start inside A
    push_pair(0, 0, 10, 0, 0, 0, 0, 10);
    push_pair(0, 0, 10, 0, 10, 0, 10, 10);
    push_pair(0, 0, 10, 10, 5, 5, 20, -10);
    // parallel, collinear overlapping, zero length
    push_pair(0, 0, 10, 0, 0, 5, 10, 5);
    push_pair(0, 0, 10, 0, 5, 0, 20, 0);
    push_pair(3, 3, 3, 3, 0, 0, 10, 10);
    push_pair(0, 0, 0, 0, 0, 0, 0, 0);
    // lines cross but outside one segment
    push_pair(0, 0, 10, 0, 20, -5, 20, 5);
    push_pair(0, 0, 10, 10, 0, 10, 4, 6);
    // truncation toward zero with negative quotients
    push_pair(0, 0, -7, -3, -5, 1, -2, -4);
    push_pair(1, 0, -6, 5, -3, -2, 2, 7);
    // full-scale coordinates
    push_pair(mn, mn, mx, mx, mn, mx, mx, mn);
    push_pair(mx, mn, mn, mx, mn, mn, mx, mx);
    push_pair(mn, 0, mx, 0, 0, mn, 0, mx);
    push_pair(mx, mx, mx, mx, mn, mn, mn, mn);
    push_pair(mn, mn, mx, mn, mx, mx, mn, mn);
    push_pair(-1, -1, mx, 1, 0, mn, 1, mx);
    repeat (1600) push_random_pair();
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
    end else begin
      if (start && !busy) void'(pending_pairs.pop_front());
      if (pending_pairs.size() > 300) calm_tail <= 0;
      else calm_tail <= 1;
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        start <= 0;
      end else if (!calm_tail && $urandom_range(0, 15) == 0) begin
        stall_left <= $urandom_range(0, 14);
        start <= 0;
      end else if (pending_pairs.size() > 0) begin
        start <= 1;
        a_start_x <= pending_pairs[0].asx; a_start_y <= pending_pairs[0].asy;
        a_end_x   <= pending_pairs[0].aex; a_end_y   <= pending_pairs[0].aey;
        b_start_x <= pending_pairs[0].bsx; b_start_y <= pending_pairs[0].bsy;
        b_end_x   <= pending_pairs[0].bex; b_end_y   <= pending_pairs[0].bey;
      end else begin
        start <= 0;
      end
    end
  end

  // predictor runs on every accepted word
  always @(posedge clk) begin
    seg_pair_t p;
    if (!rst && start && !busy) begin
      p.asx = a_start_x; p.asy = a_start_y; p.aex = a_end_x; p.aey = a_end_y;
      p.bsx = b_start_x; p.bsy = b_start_y; p.bex = b_end_x; p.bey = b_end_y;
      expected_crossings.push_back(predict_crossing(p));
    end
  end

  // monitor
  always @(posedge clk) begin
    crossing_t e;
    if (!rst && done) begin
      if (expected_crossings.size() == 0) begin
        $error("result with nothing expected: hit=%0b x=%0d y=%0d", hit, point_x, point_y);
        fail_count++;
      end else begin
        e = expected_crossings.pop_front();
        if (hit !== e.hit) begin
          $error("hit: expected %0b actual %0b", e.hit, hit);
          fail_count++;
        end
        if (point_x !== e.px) begin
          $error("point_x: expected %0d actual %0d", e.px, point_x);
          fail_count++;
        end
        if (point_y !== e.py) begin
          $error("point_y: expected %0d actual %0d", e.py, point_y);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("segment_intersection regression: fail");
      $finish;
    end
  end

  initial begin
    rst = 1;
    start = 0;
    {a_start_x, a_start_y, a_end_x, a_end_y} = '0;
    {b_start_x, b_start_y, b_end_x, b_end_y} = '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    wait (pending_pairs.size() == 0 && !start);
    wait (expected_crossings.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && expected_crossings.size() == 0) begin
      $display("segment_intersection regression: pass");
    end else begin
      if (expected_crossings.size() != 0)
        $error("%0d results never arrived", expected_crossings.size());
      $display("segment_intersection regression: fail");
    end
    $finish;
  end

endmodule

// ----- segment_intersection.f -----
src/segi_pkg.sv
src/segi_div.sv
src/segment_intersection.sv
test/tb.sv
